/* design/ekvlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekvlp_pkg
// Shared types and constants for the escaped key/value line parser.
// ----------------------------------------------------------------------------
package ekvlp_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [2:0] KIND_PATH_CHAR = 3'd0;
    localparam logic [2:0] KIND_SEG_END   = 3'd1;
    localparam logic [2:0] KIND_PATH_END  = 3'd2;
    localparam logic [2:0] KIND_KEY_CHAR  = 3'd3;
    localparam logic [2:0] KIND_VAL_CHAR  = 3'd4;

    typedef struct packed {
        logic [7:0] out_char;
        logic [2:0] token_kind;
        logic       pair_end;
        logic       keep;
        logic       last;
    } t_result;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_N:    r = CH_LF;
            CH_R:    r = CH_CR;
            CH_T:    r = CH_TAB;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

/* design/escaped_kv_line_parser.sv */
`timescale 1ns / 1ps
// Input beats are registered before parsing. Throughput: one input beat per cycle unless
// stalled; a beat that both emits a token and closes the line at end of buffer gives two
// results, which leave one per cycle, unless the output stalls, from a 4-entry result buffer.
// The input stalls while the input register is full and the buffer holds more than two results.
// Reset (synchronous, active low) empties both stages and returns to start of line.
// ----------------------------------------------------------------------------
// escaped_kv_line_parser
// Byte-wide tokenizer for path lines and escaped key=value lines.
// ----------------------------------------------------------------------------
module escaped_kv_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_buffer,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic [2:0] o_token_kind,
    output logic       o_pair_end,
    output logic       o_keep,
    output logic       o_last
);

    typedef enum logic [1:0] {
        MODE_NEWLINE = 2'd0,
        MODE_PATH    = 2'd1,
        MODE_KEY     = 2'd2,
        MODE_VALUE   = 2'd3
    } t_mode;

    t_mode      r_mode, n_mode;
    logic       r_esc, n_esc;
    logic       r_fpn, n_fpn;
    logic       r_vne, n_vne;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;

    ekvlp_pkg::t_result r_fifo [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    ekvlp_pkg::t_result slot0, slot1;
    logic [1:0] nres;
    logic       fire;
    logic       pop;
    logic       accept;

    ekvlp_pkg::t_result chr, mrk;
    logic       chr_valid, mrk_valid;
    logic       consumed, is_nl, do_char;
    logic [7:0] ch;

    assign fire       = r_in_valid && (r_count <= 3'd2);
    assign o_in_stall = r_in_valid && !(r_count <= 3'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign pop        = o_out_valid && !i_out_stall;

    assign o_out_char   = r_fifo[r_rd_ptr].out_char;
    assign o_token_kind = r_fifo[r_rd_ptr].token_kind;
    assign o_pair_end   = r_fifo[r_rd_ptr].pair_end;
    assign o_keep       = r_fifo[r_rd_ptr].keep;
    assign o_last       = r_fifo[r_rd_ptr].last;

    always_comb begin
        n_mode    = r_mode;
        n_esc     = r_esc;
        n_fpn     = r_fpn;
        n_vne     = r_vne;
        chr       = '0;
        mrk       = '0;
        chr_valid = 1'b0;
        mrk_valid = 1'b0;
        consumed  = 1'b0;
        do_char   = 1'b0;
        ch        = r_in_byte;
        is_nl     = (r_in_byte == ekvlp_pkg::CH_LF) || (r_in_byte == ekvlp_pkg::CH_CR);

        if (!is_nl) begin
            if (n_mode == MODE_NEWLINE) begin
                n_fpn = 1'b0;
                n_vne = 1'b0;
                n_esc = 1'b0;
                if (r_in_byte == ekvlp_pkg::CH_SLASH) begin
                    n_mode   = MODE_PATH;
                    consumed = 1'b1;
                end else begin
                    n_mode = MODE_KEY;
                end
            end
            if (!consumed) begin
                if (n_esc) begin
                    n_esc   = 1'b0;
                    ch      = ekvlp_pkg::unescape(r_in_byte);
                    do_char = 1'b1;
                end else if (r_in_byte == ekvlp_pkg::CH_BSL) begin
                    n_esc = 1'b1;
                end else if (n_mode == MODE_PATH && r_in_byte == ekvlp_pkg::CH_SLASH) begin
                    chr_valid      = 1'b1;
                    chr.token_kind = ekvlp_pkg::KIND_SEG_END;
                    chr.keep       = n_fpn;
                    n_fpn          = 1'b0;
                end else if (n_mode == MODE_KEY && r_in_byte == ekvlp_pkg::CH_EQ) begin
                    n_mode = MODE_VALUE;
                    n_vne  = 1'b0;
                end else begin
                    do_char = 1'b1;
                end
            end
            if (do_char) begin
                chr_valid    = 1'b1;
                chr.out_char = ch;
                if (n_mode == MODE_PATH) begin
                    n_fpn          = 1'b1;
                    chr.token_kind = ekvlp_pkg::KIND_PATH_CHAR;
                end else if (n_mode == MODE_VALUE) begin
                    n_vne          = 1'b1;
                    chr.token_kind = ekvlp_pkg::KIND_VAL_CHAR;
                end else begin
                    n_fpn          = 1'b1;
                    chr.token_kind = ekvlp_pkg::KIND_KEY_CHAR;
                end
            end
        end

        // line close: newline byte, or end of buffer with an open line
        if (is_nl || (r_in_eob && n_mode != MODE_NEWLINE)) begin
            mrk_valid = (n_mode != MODE_NEWLINE);
            unique case (n_mode)
                MODE_PATH: begin
                    mrk.token_kind = ekvlp_pkg::KIND_PATH_END;
                    mrk.keep       = n_fpn;
                end
                MODE_KEY: begin
                    mrk.token_kind = ekvlp_pkg::KIND_KEY_CHAR;
                    mrk.pair_end   = 1'b1;
                end
                MODE_VALUE: begin
                    mrk.token_kind = ekvlp_pkg::KIND_VAL_CHAR;
                    mrk.pair_end   = 1'b1;
                    mrk.keep       = n_fpn & n_vne;
                end
                default: begin
                    mrk.token_kind = ekvlp_pkg::KIND_PATH_CHAR;
                end
            endcase
            n_mode = MODE_NEWLINE;
            n_esc  = 1'b0;
            n_fpn  = 1'b0;
            n_vne  = 1'b0;
        end

        slot0 = '0;
        slot1 = '0;
        if (chr_valid) begin
            slot0      = chr;
            slot0.last = !mrk_valid;
            slot1      = mrk;
            slot1.last = 1'b1;
        end else begin
            slot0      = mrk;
            slot0.last = 1'b1;
        end
        nres = {1'b0, chr_valid} + {1'b0, mrk_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NEWLINE;
            r_esc      <= 1'b0;
            r_fpn      <= 1'b0;
            r_vne      <= 1'b0;
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode   <= n_mode;
                r_esc    <= n_esc;
                r_fpn    <= n_fpn;
                r_vne    <= n_vne;
                r_wr_ptr <= r_wr_ptr + nres;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (fire ? {1'b0, nres} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_end_of_buffer;
        end
        if (fire && nres != 2'd0) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (fire && nres == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= slot1;
        end
    end

endmodule

/* tb/tb_escaped_kv_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_kv_line_parser
// Self-checking bench for the escaped key/value line parser. A scoreboard
// class predicts the token stream from each accepted input beat and compares
// every output beat in order. The stimulus is a directed set of lines and then
// random path, key=value and noise lines. Both sides idle at random, and the
// run includes a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_escaped_kv_line_parser;

    typedef enum logic [1:0] {LM_START, LM_PATH, LM_KEY, LM_VALUE} t_line_mode;

    class token_scoreboard;
        t_line_mode mode = LM_START;
        bit         esc = 1'b0;
        bit         head_nz = 1'b0;
        bit         val_nz = 1'b0;
        ekvlp_pkg::t_result tokens_due[$];
        int         n_bytes = 0;
        int         n_tokens = 0;
        int         n_path_lines = 0;
        int         n_pair_lines = 0;
        int         n_pairs_kept = 0;
        int         errors = 0;

        function void push(logic [7:0] ch, logic [2:0] kind, bit pe, bit kp);
            ekvlp_pkg::t_result t;
            t.out_char   = ch;
            t.token_kind = kind;
            t.pair_end   = pe;
            t.keep       = kp;
            t.last       = 1'b0;
            tokens_due.push_back(t);
        endfunction

        function void add_char(logic [7:0] ch);
            if (mode == LM_PATH) begin
                head_nz = 1'b1;
                push(ch, ekvlp_pkg::KIND_PATH_CHAR, 1'b0, 1'b0);
            end else if (mode == LM_VALUE) begin
                val_nz = 1'b1;
                push(ch, ekvlp_pkg::KIND_VAL_CHAR, 1'b0, 1'b0);
            end else begin
                head_nz = 1'b1;
                push(ch, ekvlp_pkg::KIND_KEY_CHAR, 1'b0, 1'b0);
            end
        endfunction

        function void close_line();
            if (mode == LM_PATH) begin
                push(8'h00, ekvlp_pkg::KIND_PATH_END, 1'b0, head_nz);
                n_path_lines++;
            end else if (mode == LM_KEY) begin
                push(8'h00, ekvlp_pkg::KIND_KEY_CHAR, 1'b1, 1'b0);
                n_pair_lines++;
            end else if (mode == LM_VALUE) begin
                push(8'h00, ekvlp_pkg::KIND_VAL_CHAR, 1'b1, head_nz & val_nz);
                n_pair_lines++;
                if (head_nz & val_nz)
                    n_pairs_kept++;
            end
            mode    = LM_START;
            esc     = 1'b0;
            head_nz = 1'b0;
            val_nz  = 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic eob);
            int         start_n = tokens_due.size();
            bit         taken = 1'b0;
            logic [7:0] ch;
            n_bytes++;
            if (b == ekvlp_pkg::CH_LF || b == ekvlp_pkg::CH_CR) begin
                close_line();
            end else begin
                if (mode == LM_START) begin
                    head_nz = 1'b0;
                    val_nz  = 1'b0;
                    esc     = 1'b0;
                    if (b == ekvlp_pkg::CH_SLASH) begin
                        mode  = LM_PATH;
                        taken = 1'b1;
                    end else begin
                        mode = LM_KEY;
                    end
                end
                if (!taken) begin
                    if (esc) begin
                        esc = 1'b0;
                        case (b)
                            ekvlp_pkg::CH_N: ch = ekvlp_pkg::CH_LF;
                            ekvlp_pkg::CH_R: ch = ekvlp_pkg::CH_CR;
                            ekvlp_pkg::CH_T: ch = ekvlp_pkg::CH_TAB;
                            default:         ch = b;
                        endcase
                        add_char(ch);
                    end else if (b == ekvlp_pkg::CH_BSL) begin
                        esc = 1'b1;
                    end else if (mode == LM_PATH && b == ekvlp_pkg::CH_SLASH) begin
                        push(8'h00, ekvlp_pkg::KIND_SEG_END, 1'b0, head_nz);
                        head_nz = 1'b0;
                    end else if (mode == LM_KEY && b == ekvlp_pkg::CH_EQ) begin
                        mode   = LM_VALUE;
                        val_nz = 1'b0;
                    end else begin
                        add_char(b);
                    end
                end
            end
            if (eob && mode != LM_START)
                close_line();
            if (tokens_due.size() > start_n)
                tokens_due[tokens_due.size() - 1].last = 1'b1;
        endfunction

        function void cmp_field(string name, logic [7:0] e, logic [7:0] g);
            if (g !== e) begin
                $error("%s: expected %0h, got %0h", name, e, g);
                errors++;
            end
        endfunction

        function void check_token(ekvlp_pkg::t_result got);
            ekvlp_pkg::t_result want;
            if (tokens_due.size() == 0) begin
                $error("unexpected beat: out_char %0h token_kind %0d pair_end %0b",
                       got.out_char, got.token_kind, got.pair_end);
                errors++;
                return;
            end
            want = tokens_due.pop_front();
            n_tokens++;
            cmp_field("out_char", want.out_char, got.out_char);
            cmp_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
            cmp_field("pair_end", 8'(want.pair_end), 8'(got.pair_end));
            cmp_field("keep", 8'(want.keep), 8'(got.keep));
            cmp_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_buffer = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_char;
    logic [2:0] o_token_kind;
    logic       o_pair_end;
    logic       o_keep;
    logic       o_last;

    token_scoreboard    sb = new;
    ekvlp_pkg::t_result seen;
    bit                 quiet = 1'b0;
    int                 holds_asked = 0;
    int                 holds_done = 0;
    int                 n_sent = 0;

    escaped_kv_line_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_token_kind    (o_token_kind),
        .o_pair_end      (o_pair_end),
        .o_keep          (o_keep),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_byte(i_in_byte, i_end_of_buffer);
            if (o_out_valid && !i_out_stall) begin
                seen.out_char   = o_out_char;
                seen.token_kind = o_token_kind;
                seen.pair_end   = o_pair_end;
                seen.keep       = o_keep;
                seen.last       = o_last;
                sb.check_token(seen);
            end
        end
    end

    // output side: random stalls, quiet stretches, and requested long holds
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 10);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("escaped_kv_line_parser: mismatch");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic eob);
        if (!quiet && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic send_text(input string s, input logic eob_at_end);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], eob_at_end && (i == s.len() - 1));
    endtask

    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(11))
            0: c = ekvlp_pkg::CH_SLASH;
            1: c = ekvlp_pkg::CH_EQ;
            2: c = ekvlp_pkg::CH_BSL;
            3: begin
                case ($urandom_range(2))
                    0:       c = ekvlp_pkg::CH_N;
                    1:       c = ekvlp_pkg::CH_R;
                    default: c = ekvlp_pkg::CH_T;
                endcase
            end
            4:       c = 8'h00;
            5:       c = 8'($urandom_range(255));
            default: c = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        return c;
    endfunction

    task automatic send_random_line();
        int sel;
        int len;
        sel = $urandom_range(9);
        if (sel < 4) begin
            send_beat(ekvlp_pkg::CH_SLASH, 1'b0);
            len = $urandom_range(0, 7);
            for (int i = 0; i < len; i++)
                send_beat(pick_char(), 1'b0);
        end else if (sel < 8) begin
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
                send_beat(pick_char(), 1'b0);
            if ($urandom_range(9) != 0)
                send_beat(ekvlp_pkg::CH_EQ, 1'b0);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++)
                send_beat(pick_char(), 1'b0);
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_beat(8'($urandom_range(255)), 1'b0);
        end
        case ($urandom_range(9))
            6, 7: send_beat(ekvlp_pkg::CH_CR, 1'b0);
            8: begin
                send_beat(ekvlp_pkg::CH_BSL, 1'b0);
                send_beat(ekvlp_pkg::CH_LF, 1'b0);
            end
            9:       send_beat(pick_char(), 1'b1);
            default: send_beat(ekvlp_pkg::CH_LF, 1'b0);
        endcase
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bare slash, empty and escaped segments, escapes, '=' in value,
        // empty line, empty key, escaped line end, extreme bytes, flushes
        send_text("/\n", 1'b0);
        send_text("/a//\\/\n", 1'b0);
        send_text("k\\n=v=\\t\r", 1'b0);
        send_text("\n", 1'b0);
        send_beat(ekvlp_pkg::CH_EQ, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("\\\n", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("\\r", 1'b1);
        send_text("/", 1'b1);
        drain_tokens();

        while (n_sent < 650) begin
            if (n_sent >= 250 && holds_asked == 0)
                holds_asked = 1;
            quiet = (n_sent >= 400 && n_sent < 500);
            send_random_line();
            if (n_sent >= 550 && n_sent < 565)
                drain_tokens();
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.tokens_due.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("%0d input beats, %0d output beats checked", sb.n_bytes, sb.n_tokens);
        $display("%0d path lines, %0d key/value lines (%0d kept)",
                 sb.n_path_lines, sb.n_pair_lines, sb.n_pairs_kept);
        if (sb.errors == 0 && sb.tokens_due.size() == 0)
            $display("escaped_kv_line_parser: match");
        else
            $display("escaped_kv_line_parser: mismatch");
        $finish;
    end

endmodule
